@@ rtl/hdlcrx_pkg.sv @@
// ----------------------------------------------------------------------------
// HDLC receive FIFO package
// Shared constants, command codes and status codes of the receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package hdlcrx_pkg;

	localparam int FIFO_DEPTH = 32;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int THR_W      = 6;
	localparam int FILL_W     = 6;
	localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam int ADDR_W     = 4;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_EN_LEVEL  = 2'd1,
		REG_EN_END    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	localparam logic [1:0] LVL_EMPTY = 2'd0;
	localparam logic [1:0] LVL_BELOW = 2'd1;
	localparam logic [1:0] LVL_ABOVE = 2'd3;

	localparam logic [1:0] POS_PACKET = 2'd0;
	localparam logic [1:0] POS_FIRST  = 2'd1;
	localparam logic [1:0] POS_LAST   = 2'd2;
	localparam logic [1:0] POS_FLUSH  = 2'd3;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

	function automatic logic count_ge(input logic [CNT_W-1:0] cnt,
	                                  input logic [THR_W-1:0] thr);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(cnt);
		b = CMP_W'(thr);
		return a >= b;
	endfunction

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/hdlc_rx_fifo_status.sv @@
// ----------------------------------------------------------------------------
// HDLC receive FIFO with status bits
// Byte FIFO with packet level status, interrupt flags and overflow dropping.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the slave stream carries one command (push, pop, flush or
// clear interrupt flags), a data byte and, on tlast, the last-of-packet mark.
// Every accepted item produces exactly one result item on the master stream,
// holding the popped byte, the level and byte-position codes, the sticky
// interrupt flags, the IRQ pulse, the receiver disable request, the overflow
// mark and the fill count after the item.
// The result appears in the cycle after the item is accepted; one item can be
// accepted every cycle while results are taken. The byte store is a RAM with
// a registered read, so a popped byte is output in the cycle after the pop.
// The APB port sets the level threshold and the two interrupt enables.
// Reset empties the FIFO, clears the flags and loads the default threshold.
// When the receiver stalls, the result is held and no new item is accepted
// until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_rx_fifo_status (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [1:0] command, [9:2] data_byte, [15:10] zero
	input  wire logic [15:0]                   s_tdata,
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [7:0] read_data, [9:8] level_status, [11:10] byte_position,
	// [12] level_irq_flag, [13] end_irq_flag, [14] irq_pulse,
	// [15] receiver_disable, [16] overflow, [22:17] fill_count, [23] zero
	output logic [23:0]                        m_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [hdlcrx_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	import hdlcrx_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             en_level_q;
	logic             en_end_q;

	logic [PTR_W-1:0] rp_q, rp_n;
	logic [PTR_W-1:0] wp_q, wp_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [1:0]       level_q, level_n;
	logic [1:0]       pos_q, pos_n;
	logic             lflag_q, lflag_n;
	logic             eflag_q, eflag_n;
	logic             drop_q, drop_n;

	logic             accept;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;
	cmd_t             cmd;
	logic [7:0]       data_byte;
	logic             ram_we, ram_re;
	logic [7:0]       ram_rdata;
	logic             pop_hit, irq, rxdis, ovf;

	logic             out_valid_q;
	logic             pop_hit_q;
	logic [1:0]       level_out_q;
	logic [1:0]       pos_out_q;
	logic             lflag_out_q;
	logic             eflag_out_q;
	logic             irq_out_q;
	logic             rxdis_out_q;
	logic             ovf_out_q;
	logic [FILL_W-1:0] fill_out_q;
	logic [CMP_W-1:0] cnt_ext;

	assign cmd       = cmd_t'(s_tdata[1:0]);
	assign data_byte = s_tdata[9:2];
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			en_level_q <= 1'b0;
			en_end_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THRESHOLD: thr_q      <= pwdata[THR_W-1:0];
				REG_EN_LEVEL:  en_level_q <= pwdata[0];
				REG_EN_END:    en_end_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_THRESHOLD: prdata = 32'(thr_q);
			REG_EN_LEVEL:  prdata = 32'(en_level_q);
			REG_EN_END:    prdata = 32'(en_end_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		rp_n    = rp_q;
		wp_n    = wp_q;
		cnt_n   = cnt_q;
		level_n = level_q;
		pos_n   = pos_q;
		lflag_n = lflag_q;
		eflag_n = eflag_q;
		drop_n  = drop_q;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		pop_hit = 1'b0;
		irq     = 1'b0;
		rxdis   = 1'b0;
		ovf     = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				rxdis = 1'b1;
				if (drop_q) begin
					if (s_tlast) begin
						drop_n = 1'b0;
					end
				end else if (cnt_q >= CNT_W'(FIFO_DEPTH)) begin
					rp_n    = '0;
					wp_n    = '0;
					cnt_n   = '0;
					level_n = LVL_EMPTY;
					pos_n   = POS_FLUSH;
					ovf     = 1'b1;
					drop_n  = !s_tlast;
				end else begin
					ram_we = accept;
					wp_n   = next_ptr(wp_q);
					cnt_n  = cnt_q + CNT_W'(1);
					if (s_tlast) begin
						if (count_ge(cnt_n, thr_q)) begin
							level_n = LVL_ABOVE;
							if (en_level_q) begin
								lflag_n = 1'b1;
								irq     = 1'b1;
							end
						end else begin
							level_n = LVL_BELOW;
						end
						if (en_end_q) begin
							eflag_n = 1'b1;
							irq     = 1'b1;
						end
						pos_n = POS_FIRST;
					end
				end
			end
			CMD_POP: begin
				if (cnt_q != '0) begin
					ram_re  = accept;
					pop_hit = 1'b1;
					rp_n    = next_ptr(rp_q);
					cnt_n   = cnt_q - CNT_W'(1);
				end
				if (cnt_n > CNT_W'(1)) begin
					pos_n = POS_PACKET;
				end else if (cnt_n == CNT_W'(1)) begin
					pos_n = POS_LAST;
				end
				if (count_ge(cnt_n, thr_q)) begin
					level_n = LVL_ABOVE;
				end else if (cnt_n != '0) begin
					level_n = LVL_BELOW;
				end else begin
					level_n = LVL_EMPTY;
				end
			end
			CMD_FLUSH: begin
				rp_n    = '0;
				wp_n    = '0;
				cnt_n   = '0;
				level_n = LVL_EMPTY;
				pos_n   = POS_FLUSH;
			end
			CMD_CLEAR: begin
				lflag_n = 1'b0;
				eflag_n = 1'b0;
			end
			default: ;
		endcase
	end

	assign cnt_ext = CMP_W'(cnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			level_q <= LVL_EMPTY;
			pos_q   <= POS_FLUSH;
			lflag_q <= 1'b0;
			eflag_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			rp_q    <= rp_n;
			wp_q    <= wp_n;
			cnt_q   <= cnt_n;
			level_q <= level_n;
			pos_q   <= pos_n;
			lflag_q <= lflag_n;
			eflag_q <= eflag_n;
			drop_q  <= drop_n;
		end
	end

	hdlcrx_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_hit_q   <= pop_hit;
			level_out_q <= level_n;
			pos_out_q   <= pos_n;
			lflag_out_q <= lflag_n;
			eflag_out_q <= eflag_n;
			irq_out_q   <= irq;
			rxdis_out_q <= rxdis;
			ovf_out_q   <= ovf;
			fill_out_q  <= cnt_ext[FILL_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, fill_out_q, ovf_out_q, rxdis_out_q, irq_out_q,
	                   eflag_out_q, lflag_out_q, pos_out_q, level_out_q,
	                   (pop_hit_q ? ram_rdata : 8'd0)};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("fill count exceeds the FIFO depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

	a_overflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16]) |-> (m_tdata[22:17] == '0))
		else $error("overflow result shows a nonempty FIFO");

	a_no_write_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in the same cycle");
`endif

endmodule

`default_nettype wire

@@ rtl/hdlcrx_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlcrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
